// ===== rtl/core/bfgl_pkg.sv =====
// ----------------------------------------------------------------------------
// bfgl_pkg: shared types and constants for the bitmap font glyph layout
// Character classes, glyph sheet geometry, the glyph width table and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package bfgl_pkg;

  // Cursor motion constants. The tab stop must be a power of two.
  localparam int TabStop      = 32;
  localparam int LineAdvance  = 10;
  localparam int SpaceAdvance = 4;

  localparam int CellW   = 6;
  localparam int CellH   = 9;
  localparam int GlyphH  = 9;
  localparam int NumCells = 96;
  localparam logic [6:0] BadCell = 7'd95;

  localparam logic [7:0] CodeNull    = 8'h00;
  localparam logic [7:0] CodeTab     = 8'h09;
  localparam logic [7:0] CodeNewline = 8'h0A;
  localparam logic [7:0] CodeSpace   = 8'h20;
  localparam logic [7:0] CodeDel     = 8'h7F;

  typedef enum logic [2:0] {
    CFG_U_BASE  = 3'd0,
    CFG_V_BASE  = 3'd1,
    CFG_PALETTE = 3'd2,
    CFG_PAGE    = 3'd3,
    CFG_LAYER   = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    KIND_NULL,
    KIND_TAB,
    KIND_NEWLINE,
    KIND_SPACE,
    KIND_GLYPH
  } char_kind_t;

  // Decoded character as it leaves the glyph lookup stage.
  typedef struct packed {
    char_kind_t  kind;
    logic [6:0]  sheet_cell;
    logic [3:0]  width;
  } glyph_info_t;

  localparam logic [3:0] GlyphWidth [NumCells] = '{
    4'd0, 4'd2, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd2,
    4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd6, 4'd2, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd2, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd4, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd3, 4'd6, 4'd3, 4'd4, 4'd6,
    4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6,
    4'd5, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd5, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd5, 4'd4, 4'd2, 4'd4, 4'd6, 4'd6
  };

endpackage

// ===== rtl/core/bfgl_glyph_rom.sv =====
// ----------------------------------------------------------------------------
// bfgl_glyph_rom: character decode and glyph width lookup
// Classifies the character byte and reads the glyph width table with a
// registered read port, one request per cycle while en is high.
// ----------------------------------------------------------------------------
module bfgl_glyph_rom (
  input  logic                 clk,
  input  logic                 en,
  input  logic [7:0]           char_code,
  output bfgl_pkg::glyph_info_t info
);
  import bfgl_pkg::*;

  char_kind_t kind;
  logic [6:0] cell_idx;

  always_comb begin
    cell_idx = BadCell;
    case (char_code)
      CodeNull:    kind = KIND_NULL;
      CodeTab:     kind = KIND_TAB;
      CodeNewline: kind = KIND_NEWLINE;
      CodeSpace:   kind = KIND_SPACE;
      default: begin
        kind = KIND_GLYPH;
        // Printable codes map onto the sheet; all others draw the invalid glyph.
        if (char_code > CodeSpace && char_code < CodeDel) begin
          cell_idx = 7'(char_code - CodeSpace);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info.kind       <= kind;
      info.sheet_cell <= cell_idx;
      info.width      <= GlyphWidth[cell_idx];
    end
  end

endmodule

// ===== rtl/core/bfgl_cursor.sv =====
// ----------------------------------------------------------------------------
// bfgl_cursor: text cursor state and update
// Holds cursor x/y and the line start x, applies the start load and the
// per-character motion, and presents the drawing position of the item.
// ----------------------------------------------------------------------------
module bfgl_cursor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  bfgl_pkg::glyph_info_t info,
  input  logic                  start,
  input  logic [15:0]           start_x,
  input  logic [15:0]           start_y,
  output logic [15:0]           pos_x,
  output logic [15:0]           pos_y
);
  import bfgl_pkg::*;

  localparam logic [17:0] TabMask = 18'(TabStop - 1);

  logic [15:0] cursor_x, cursor_y, line_start_x;
  logic [15:0] cursor_x_next, cursor_y_next, line_start_x_next;
  logic [15:0] base_line;
  logic [17:0] tab_t, tab_mag, tab_floor, tab_res;
  logic        tab_neg;

  assign pos_x     = start ? start_x : cursor_x;
  assign pos_y     = start ? start_y : cursor_y;
  assign base_line = start ? start_x : line_start_x;

  // Tab rounds x + TabStop - 1 toward zero to a tab stop, as a truncating
  // remainder does, so a negative sum is rounded on its magnitude.
  always_comb begin
    tab_t     = {{2{pos_x[15]}}, pos_x} + TabMask;
    tab_neg   = tab_t[17];
    tab_mag   = tab_neg ? (18'd0 - tab_t) : tab_t;
    tab_floor = tab_mag & ~TabMask;
    tab_res   = tab_neg ? (18'd0 - tab_floor) : tab_floor;
  end

  always_comb begin
    cursor_x_next     = pos_x;
    cursor_y_next     = pos_y;
    line_start_x_next = base_line;
    case (info.kind)
      KIND_NULL:    cursor_x_next = pos_x;
      KIND_TAB:     cursor_x_next = tab_res[15:0];
      KIND_NEWLINE: begin
        cursor_x_next = base_line;
        cursor_y_next = pos_y + 16'(LineAdvance);
      end
      KIND_SPACE:   cursor_x_next = pos_x + 16'(SpaceAdvance);
      KIND_GLYPH:   cursor_x_next = pos_x + {12'd0, info.width};
      default:      cursor_x_next = pos_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      line_start_x <= '0;
    end else if (adv) begin
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      line_start_x <= line_start_x_next;
    end
  end

endmodule

// ===== rtl/core/bitmap_font_glyph_layout.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_glyph_layout: bitmap font text layout
// Turns a stream of character bytes into textured sprite requests.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one character per request. With tuser set the
//   cursor and the line start are first loaded from start_x/start_y. Tab,
//   newline, space and code zero only move (or keep) the cursor; every other
//   code produces one sprite request on the master stream and then advances
//   the cursor by the glyph width. Unprintable codes draw the invalid glyph.
//   The configuration port writes the sheet base, palette, page and layer;
//   the user must make writes only while no character is in flight; the
//   block itself does not enforce this. The glyph table read is registered;
//   the single cursor update stage that follows it loads the sprite into
//   m_tdata. The block takes one character per cycle unless a sprite waits
//   on a stalled master side. When the master side stalls, the sprite is
//   held in the output register; characters that make no sprite keep
//   flowing, a sprite waits behind it. Reset clears the cursor, line start,
//   configuration registers and all valid flags.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_layout (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // char_code, start_x, start_y
  input  logic        s_tuser,  // start_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,  // pos_x, pos_y, tex_u, tex_v, glyph_width,
                                // glyph_height, sprite_palette, sprite_page,
                                // sprite_layer
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bfgl_pkg::*;

  logic [7:0]  sheet_u_base, sheet_v_base, draw_layer;
  logic [15:0] palette_id, texture_page;

  logic        s_accept;
  logic        a_vld, a_adv, a_emit, out_free;
  logic        a_start;
  logic [15:0] a_start_x, a_start_y;
  glyph_info_t a_info;
  logic [15:0] pos_x, pos_y;
  logic [7:0]  u_off, v_off;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_u_base <= '0;
      sheet_v_base <= '0;
      palette_id   <= '0;
      texture_page <= '0;
      draw_layer   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_U_BASE:  sheet_u_base <= cfg_data[7:0];
        CFG_V_BASE:  sheet_v_base <= cfg_data[7:0];
        CFG_PALETTE: palette_id   <= cfg_data;
        CFG_PAGE:    texture_page <= cfg_data;
        CFG_LAYER:   draw_layer   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign a_emit   = a_info.kind == KIND_GLYPH;
  assign a_adv    = a_vld && (!a_emit || out_free);
  assign s_tready = !a_vld || a_adv;
  assign s_accept = s_tvalid && s_tready;

  bfgl_glyph_rom u_rom (
    .clk       (clk),
    .en        (s_accept),
    .char_code (s_tdata[7:0]),
    .info      (a_info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (s_tready) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      a_start   <= s_tuser;
      a_start_x <= s_tdata[23:8];
      a_start_y <= s_tdata[39:24];
    end
  end

  bfgl_cursor u_cursor (
    .clk     (clk),
    .rst     (rst),
    .adv     (a_adv),
    .info    (a_info),
    .start   (a_start),
    .start_x (a_start_x),
    .start_y (a_start_y),
    .pos_x   (pos_x),
    .pos_y   (pos_y)
  );

  assign u_off = 8'({4'd0, a_info.sheet_cell[3:0]} * 8'(CellW));
  assign v_off = 8'({5'd0, a_info.sheet_cell[6:4]} * 8'(CellH));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= a_vld && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_emit) begin
      m_tdata <= {draw_layer, texture_page, palette_id, 4'(GlyphH), a_info.width,
                  sheet_v_base + v_off, sheet_u_base + u_off, pos_y, pos_x};
    end
  end

endmodule

// ===== rtl/core/bfgl_checker.sv =====
// ----------------------------------------------------------------------------
// bfgl_checker: port-level checks for the glyph layout block
// Watches the stream ports for output hold, the state after reset and sprite field sanity.
// ----------------------------------------------------------------------------
module bfgl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);
  import bfgl_pkg::*;

  // A stalled sprite stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("sprite dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("sprite changed while stalled");

  // After reset the pipeline is empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  a_height: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:52] == 4'(GlyphH))
    else $error("wrong glyph height");

  // Every drawn glyph has a nonzero width of at most one cell.
  a_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[51:48] >= 4'd2) && (m_tdata[51:48] <= 4'(CellW)))
    else $error("glyph width out of range");

endmodule

bind bitmap_font_glyph_layout bfgl_checker u_bfgl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/glyph_layout_checker.sv =====
// ----------------------------------------------------------------------------
// glyph_layout_checker: sprite scoreboard for the bitmap font glyph layout
// Watches the character, sprite and register channels and keeps its own
// cursor, line start and register copies. For every accepted character it
// works out the sprite that should come out (if any), queues it, and
// compares each accepted sprite field by field against the oldest one.
// ----------------------------------------------------------------------------
module glyph_layout_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // char_code, start_x, start_y
  input  logic        s_tuser,   // start_of_string
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,   // pos_x, pos_y, tex_u, tex_v, glyph_width,
                                 // glyph_height, sprite_palette, sprite_page,
                                 // sprite_layer
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned error_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bfgl_pkg::*;

  // Field order matches m_tdata, last member in the lowest bits.
  typedef struct packed {
    logic [7:0]  layer;
    logic [15:0] page;
    logic [15:0] palette;
    logic [3:0]  height;
    logic [3:0]  width;
    logic [7:0]  tex_v;
    logic [7:0]  tex_u;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } sprite_t;

  localparam logic [3:0] GlyphAdvance [96] = '{
    4'd0, 4'd2, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd2, 4'd3, 4'd3, 4'd4, 4'd6,
    4'd3, 4'd6, 4'd2, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd2, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd3,
    4'd6, 4'd3, 4'd4, 4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6,
    4'd5, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd4, 4'd2, 4'd4, 4'd6, 4'd6
  };

  logic [15:0] cur_x, cur_y, line_x;
  logic [7:0]  u_base, v_base, layer_reg;
  logic [15:0] palette_reg, page_reg;

  sprite_t     sprite_q[$];
  int unsigned mismatches = 0;
  int unsigned sprite_no  = 0;

  // Applies one character to the cursor; returns 1 when it draws a sprite.
  function automatic bit layout_char(input logic [7:0] code, input logic load,
                                     input logic [15:0] sx, input logic [15:0] sy,
                                     output sprite_t spr);
    int         t;
    int         r;
    logic [6:0] cell_idx;
    logic [3:0] w;
    spr = '0;
    if (load) begin
      cur_x  = sx;
      line_x = sx;
      cur_y  = sy;
    end
    if (code == CodeNull) return 1'b0;
    if (code == CodeTab) begin
      // Truncating remainder: negative positions round toward zero.
      t = int'($signed(cur_x)) + TabStop - 1;
      r = t % TabStop;
      cur_x = 16'(t - r);
      return 1'b0;
    end
    if (code == CodeNewline) begin
      cur_x = line_x;
      cur_y = cur_y + 16'(LineAdvance);
      return 1'b0;
    end
    if (code == CodeSpace) begin
      cur_x = cur_x + 16'(SpaceAdvance);
      return 1'b0;
    end
    if (code > CodeSpace && code < CodeDel) cell_idx = 7'(code - CodeSpace);
    else cell_idx = BadCell;
    w = GlyphAdvance[cell_idx];
    spr.pos_x   = cur_x;
    spr.pos_y   = cur_y;
    spr.tex_u   = 8'(u_base + cell_idx[3:0] * CellW);
    spr.tex_v   = 8'(v_base + cell_idx[6:4] * CellH);
    spr.width   = w;
    spr.height  = 4'(GlyphH);
    spr.palette = palette_reg;
    spr.page    = page_reg;
    spr.layer   = layer_reg;
    cur_x = cur_x + 16'(w);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (seen !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t sprite %0d: %s expected %h, got %h",
                 $realtime, sprite_no, name, want, seen);
    end
  endtask

  always @(posedge clk) begin : monitor
    sprite_t want;
    sprite_t seen;
    if (rst) begin
      cur_x       = '0;
      cur_y       = '0;
      line_x      = '0;
      u_base      = '0;
      v_base      = '0;
      palette_reg = '0;
      page_reg    = '0;
      layer_reg   = '0;
      sprite_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_U_BASE:  u_base      = cfg_data[7:0];
          CFG_V_BASE:  v_base      = cfg_data[7:0];
          CFG_PALETTE: palette_reg = cfg_data;
          CFG_PAGE:    page_reg    = cfg_data;
          CFG_LAYER:   layer_reg   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (layout_char(s_tdata[7:0], s_tuser, s_tdata[23:8], s_tdata[39:24], want))
          sprite_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        seen = m_tdata;
        if (sprite_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t sprite with nothing expected: %h", $realtime, m_tdata);
        end else begin
          want = sprite_q.pop_front();
          check_field("pos_x", want.pos_x, seen.pos_x);
          check_field("pos_y", want.pos_y, seen.pos_y);
          check_field("tex_u", 16'(want.tex_u), 16'(seen.tex_u));
          check_field("tex_v", 16'(want.tex_v), 16'(seen.tex_v));
          check_field("glyph_width", 16'(want.width), 16'(seen.width));
          check_field("glyph_height", 16'(want.height), 16'(seen.height));
          check_field("sprite_palette", want.palette, seen.palette);
          check_field("sprite_page", want.page, seen.page);
          check_field("sprite_layer", 16'(want.layer), 16'(seen.layer));
        end
        sprite_no++;
      end
    end
    pending_count <= sprite_q.size();
    error_count   <= mismatches;
  end

endmodule

// ===== tb/bitmap_font_glyph_layout_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_glyph_layout_tb: top level testbench for the glyph layout
// Drives character requests and register writes, stalls the sprite side at
// random and reports the verdict. Prediction and comparison live in the
// checker instantiated next to the block.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_layout_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfgl_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [95:0] m_tdata;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = CFG_U_BASE;
  logic [15:0] cfg_data  = '0;

  int unsigned error_count;
  int unsigned pending_count;

  bit hold_req = 1'b0;   // asks the sprite side for one long stall
  bit quiet    = 1'b0;   // no idling on either side
  int gap_pct  = 20;     // chance of a sender gap after a request

  bitmap_font_glyph_layout dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glyph_layout_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("** bitmap_font_glyph_layout: FAILED **");
    $finish;
  end

  // Sprite side: random stall bursts, plus one long stall on request.
  initial begin : sprite_sink
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [7:0] code, input logic load,
                           input logic [15:0] sx, input logic [15:0] sy);
    s_tdata  <= {sy, sx, code};
    s_tuser  <= load;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Waits for every expected sprite, then lets the pipeline empty out.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] u, input logic [7:0] v,
                              input logic [15:0] pal, input logic [15:0] page,
                              input logic [7:0] layer);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_U_BASE;
    cfg_data  <= {8'h00, u};
    @(posedge clk);
    cfg_index <= CFG_V_BASE;
    cfg_data  <= {8'h00, v};
    @(posedge clk);
    cfg_index <= CFG_PALETTE;
    cfg_data  <= pal;
    @(posedge clk);
    cfg_index <= CFG_PAGE;
    cfg_data  <= page;
    @(posedge clk);
    cfg_index <= CFG_LAYER;
    cfg_data  <= {8'h00, layer};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_random();
    program_regs(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                 8'($urandom));
  endtask

  // String origins lean toward the wrap points of the 16-bit cursor.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'h7FC0 + 16'($urandom_range(0, 63));
      2: return 16'h8000 + 16'($urandom_range(0, 63));
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(8'h21, 8'h7E));
    else if (r < 68) return CodeSpace;
    else if (r < 74) return CodeTab;
    else if (r < 80) return CodeNewline;
    else if (r < 84) return CodeNull;
    else if (r < 92) return 8'($urandom_range(8'h7F, 8'hFF));
    else return 8'($urandom_range(8'h01, 8'h1F));
  endfunction

  // Mostly strings that open with a start flag, with stray start flags
  // mixed in. hold_at and pause_at pick the request after which the sprite
  // side stalls for long, or the sender waits until all sprites are out.
  task automatic run_text(input int count, input int hold_at, input int pause_at);
    int          n;
    int          left;
    logic        load;
    logic [15:0] sx;
    logic [15:0] sy;
    left = 0;
    for (n = 0; n < count; n++) begin
      sx = 16'($urandom);
      sy = 16'($urandom);
      if (left == 0) begin
        load = 1'b1;
        sx   = pick_coord();
        sy   = pick_coord();
        left = $urandom_range(1, 40);
      end else begin
        load = ($urandom_range(0, 29) == 0);
      end
      left--;
      send_char(pick_code(), load, sx, sy);
      if (n == hold_at) hold_req = 1'b1;
      if (n == pause_at) wait_idle();
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Cursor and registers straight out of reset.
    send_char("A", 1'b0, 16'h0000, 16'h0000);
    send_char("~", 1'b0, 16'hFFFF, 16'hFFFF);
    wait_idle();

    // Sheet base near the top so the texel coordinates wrap.
    program_regs(8'hF0, 8'hFB, 16'hFFFF, 16'h0000, 8'hFF);
    send_char("!", 1'b1, 16'h7FFF, 16'h8000);
    send_char("~", 1'b0, 16'h0000, 16'h0000);
    send_char(CodeDel, 1'b0, 16'h0000, 16'h0000);
    send_char(8'h80, 1'b0, 16'h0000, 16'h0000);
    send_char(8'hFF, 1'b0, 16'h0000, 16'h0000);
    send_char(8'h01, 1'b0, 16'h0000, 16'h0000);
    send_char(8'h1F, 1'b0, 16'h0000, 16'h0000);
    // Tabs from a negative x round toward zero, from near the top they wrap.
    send_char(CodeTab, 1'b1, 16'hFFFF, 16'h0005);
    send_char("A", 1'b0, 16'h0000, 16'h0000);
    send_char(CodeTab, 1'b1, 16'hFFD8, 16'h0005);
    send_char("\"", 1'b0, 16'h0000, 16'h0000);
    send_char(CodeTab, 1'b1, 16'h7FF0, 16'h0005);
    send_char("#", 1'b0, 16'h0000, 16'h0000);
    send_char(CodeNewline, 1'b1, 16'h0010, 16'h7FFF);
    send_char("z", 1'b0, 16'h0000, 16'h0000);
    send_char(CodeSpace, 1'b1, 16'h7FFE, 16'h0000);
    // A null code with a start flag still loads the cursor.
    send_char(CodeNull, 1'b1, 16'h1234, 16'h5678);
    send_char("B", 1'b0, 16'h0000, 16'h0000);
    send_char(CodeNull, 1'b0, 16'hFFFF, 16'hFFFF);
    send_char("W", 1'b0, 16'h0000, 16'h0000);
    send_char(CodeTab, 1'b0, 16'h0000, 16'h0000);
    send_char(CodeNewline, 1'b0, 16'h0000, 16'h0000);
    send_char("|", 1'b0, 16'h0000, 16'h0000);
    send_char(CodeSpace, 1'b1, 16'h8000, 16'h0000);
    send_char("m", 1'b0, 16'h0000, 16'h0000);
    wait_idle();

    program_regs(8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00);
    gap_pct = 20;
    run_text(240, -1, -1);
    wait_idle();

    program_regs(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_text(240, 40, -1);
    wait_idle();

    program_random();
    gap_pct = 0;
    run_text(240, -1, 120);
    wait_idle();

    program_random();
    gap_pct = 35;
    run_text(240, -1, -1);
    wait_idle();

    program_random();
    gap_pct = 20;
    run_text(240, 100, -1);
    wait_idle();

    program_random();
    quiet = 1'b1;
    run_text(220, -1, -1);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("** bitmap_font_glyph_layout: PASSED **");
    end else begin
      $display("** bitmap_font_glyph_layout: FAILED **");
    end
    $finish;
  end

endmodule
